// File: rtl/core/stkf_pkg.sv
package stkf_pkg;

   // fixed field widths of the request, response and csr channels
   localparam int ID_W        = 12;
   localparam int REQ_DATA_W  = 16;
   localparam int OUT_CNT_W   = 16;
   localparam int RSP_DATA_W  = 40;
   localparam int CFG_W       = 5;

   localparam logic [CFG_W-1:0] TOP_K_RESET = 5'd10;

endpackage

// File: rtl/core/stream_top_k_frequency_unit.sv
// Streaming top-K frequency ranker. Each request carries an item id; before the id is
// counted, the block reports the current ranking (highest count first, equal counts by
// lower id first), one response per rank, up to top_k ranks, with the last response of
// the report marked by rsp_tlast. An empty ranking reports nothing. After reset the block
// sweeps the count table to zero, one entry per cycle, and takes no request meanwhile
// (csr writes are taken at any time). Each request then goes through these steps in order:
// take it and read its count, send the n responses (n = ranks reported, held while
// rsp_tready stalls), update the count, scan the ranking (at most MAX_K entries) for the
// id, and move the entry up the list. A single compare unit and a single list read port
// are stepped by the sequencer. Ids at or above NUM_IDS and saturated counts skip the scan
// and move.
module stream_top_k_frequency_unit #(
   parameter int NUM_IDS    = 4096,
   parameter int MAX_K      = 16,
   parameter int COUNT_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: [11:0] item_value, [15:12] zero
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [stkf_pkg::REQ_DATA_W-1:0] req_tdata,
   // response: [11:0] query_value, [23:12] rec_value, [39:24] rec_count
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [stkf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast,
   // top_k register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stkf_pkg::CFG_W-1:0]      csr_data
);

   import stkf_pkg::*;

   localparam int AW     = $clog2(NUM_IDS);
   localparam int IDX_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int FILL_W = $clog2(MAX_K + 1);

   localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EMIT,
      ST_COUNT,
      ST_SCAN,
      ST_BUBBLE
   } state_type;

   // sequencer state
   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic [FILL_W-1:0]      num_ff, num_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;
   logic [CFG_W-1:0]       top_k_ff;

   // request payload and the entry being placed
   logic [ID_W-1:0]        qid_ff, qid_in;
   logic [COUNT_BITS-1:0]  mov_cnt_ff, mov_cnt_in;

   // response register, holds its own copy of the query id
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [ID_W-1:0]        rsp_qid_ff, rsp_qid_in;
   logic [ID_W-1:0]        rsp_id_ff, rsp_id_in;
   logic [COUNT_BITS-1:0]  rsp_cnt_ff, rsp_cnt_in;

   // ranked list, valid entries form the prefix [0, fill_ff)
   logic [ID_W-1:0]        top_id_ff  [MAX_K];
   logic [COUNT_BITS-1:0]  top_cnt_ff [MAX_K];

   // list read and write port
   logic [IDX_W-1:0]       rd_idx;
   logic [ID_W-1:0]        rd_id;
   logic [COUNT_BITS-1:0]  rd_cnt;
   logic                   ent_we;
   logic [IDX_W-1:0]       ent_waddr;
   logic [ID_W-1:0]        ent_wid;
   logic [COUNT_BITS-1:0]  ent_wcnt;

   // count table port
   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [COUNT_BITS-1:0]  ram_wdata;
   logic                   ram_re;
   logic [COUNT_BITS-1:0]  ram_rdata;

   logic                   req_fire;
   logic                   rsp_free;
   logic                   ahead;
   logic                   qid_in_range;
   logic [FILL_W-1:0]      k_lim;
   logic [FILL_W-1:0]      idx_next;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {OUT_CNT_W'(rsp_cnt_ff), rsp_id_ff, rsp_qid_ff};

   assign qid_in_range = (32'(qid_ff) < 32'(NUM_IDS));
   assign k_lim = (32'(top_k_ff) > 32'(MAX_K)) ? FILL_W'(MAX_K) : FILL_W'(top_k_ff);
   assign idx_next = FILL_W'(idx_ff) + FILL_W'(1);

   // single list read port: rank walk and scan use idx, the move reads the slot above
   assign rd_idx = (state_ff == ST_BUBBLE) ? (pos_ff - IDX_W'(1)) : idx_ff;
   assign rd_id  = top_id_ff[rd_idx];
   assign rd_cnt = top_cnt_ff[rd_idx];

   // shared compare: does the moving entry rank ahead of the entry read
   assign ahead = (mov_cnt_ff > rd_cnt) || ((mov_cnt_ff == rd_cnt) && (qid_ff < rd_id));

   stkf_count_ram #(
      .DEPTH (NUM_IDS),
      .WIDTH (COUNT_BITS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (AW'(req_tdata[ID_W-1:0])),
      .rd_data (ram_rdata)
   );

   assign ram_re = req_fire;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      fill_in      = fill_ff;
      num_in       = num_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      qid_in       = qid_ff;
      mov_cnt_in   = mov_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_qid_in   = rsp_qid_ff;
      rsp_id_in    = rsp_id_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      ent_we       = 1'b0;
      ent_waddr    = pos_ff;
      ent_wid      = qid_ff;
      ent_wcnt     = mov_cnt_ff;
      ram_we       = 1'b0;
      ram_waddr    = AW'(qid_ff);
      ram_wdata    = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            // zero one count entry per cycle
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(NUM_IDS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               qid_in = req_tdata[ID_W-1:0];
               idx_in = '0;
               num_in = (k_lim < fill_ff) ? k_lim : fill_ff;
               if (((k_lim < fill_ff) ? k_lim : fill_ff) != '0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_COUNT;
               end
            end
         end

         ST_EMIT: begin
            // walk ranks into the response register as it frees up
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_qid_in   = qid_ff;
               rsp_id_in    = rd_id;
               rsp_cnt_in   = rd_cnt;
               rsp_last_in  = (idx_next == num_ff);
               idx_in       = idx_ff + IDX_W'(1);
               if (idx_next == num_ff) begin
                  state_in = ST_COUNT;
               end
            end
         end

         ST_COUNT: begin
            // bump the count unless out of range or saturated
            if (qid_in_range && (ram_rdata != CNT_MAX)) begin
               mov_cnt_in = ram_rdata + COUNT_BITS'(1);
               ram_we     = 1'b1;
               ram_wdata  = mov_cnt_in;
               idx_in     = '0;
               if (fill_ff == '0) begin
                  pos_in   = '0;
                  fill_in  = FILL_W'(1);
                  state_in = ST_BUBBLE;
               end else begin
                  state_in = ST_SCAN;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            priority if (rd_id == qid_ff) begin
               pos_in   = idx_ff;
               state_in = ST_BUBBLE;
            end else if (idx_next == fill_ff) begin
               if (fill_ff != FILL_W'(MAX_K)) begin
                  // append at the first free slot
                  pos_in   = IDX_W'(fill_ff);
                  fill_in  = fill_ff + FILL_W'(1);
                  state_in = ST_BUBBLE;
               end else if (ahead) begin
                  // full list: drop the last entry in favor of this one
                  pos_in   = idx_ff;
                  state_in = ST_BUBBLE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_BUBBLE: begin
            ent_we = 1'b1;
            if ((pos_ff != '0) && ahead) begin
               // shift the entry above down, advance upward
               ent_wid  = rd_id;
               ent_wcnt = rd_cnt;
               pos_in   = pos_ff - IDX_W'(1);
            end else begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         top_k_ff     <= TOP_K_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            top_k_ff <= csr_data;
         end
      end
      num_ff      <= num_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      qid_ff      <= qid_in;
      mov_cnt_ff  <= mov_cnt_in;
      rsp_last_ff <= rsp_last_in;
      rsp_qid_ff  <= rsp_qid_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (ent_we) begin
         top_id_ff[ent_waddr]  <= ent_wid;
         top_cnt_ff[ent_waddr] <= ent_wcnt;
      end
   end

endmodule

// File: rtl/core/stkf_count_ram.sv
module stkf_count_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
